// ===== design/tcwc_pkg.sv =====
// Package for the congestion window controller: shared constants, register
// map, datapath command codes and the structs between controller and datapath.
// No dependencies.
package tcwc_pkg;

    localparam int MAX_WIN_SEG_DEF = 1024;
    localparam int SEQ_W_DEF       = 48;
    localparam int TOTAL_W         = 48;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 64;

    // register reset values
    localparam logic [15:0] SEG_RESET      = 16'd4000;
    localparam logic [10:0] INIT_LIM_RESET = 11'd512;
    localparam logic [10:0] TO_WIN_RESET   = 11'd256;
    localparam logic [6:0]  BURST_RESET    = 7'd32;
    localparam logic [3:0]  TRIG_RESET     = 4'd3;
    localparam logic [3:0]  DUP_MAX        = 4'd15;

    // register indexes (byte address is 8 times the index)
    localparam logic [2:0] REG_SEG      = 3'd0;
    localparam logic [2:0] REG_TOTAL    = 3'd1;
    localparam logic [2:0] REG_INIT_LIM = 3'd2;
    localparam logic [2:0] REG_TO_WIN   = 3'd3;
    localparam logic [2:0] REG_BURST    = 3'd4;
    localparam logic [2:0] REG_TRIG     = 3'd5;

    // event kinds
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // phases
    localparam logic [1:0] PH_SLOW  = 2'd0;
    localparam logic [1:0] PH_AVOID = 2'd1;
    localparam logic [1:0] PH_RECOV = 2'd2;

    // datapath commands
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;
    localparam logic [3:0] OP_MAXW    = 4'd2;
    localparam logic [3:0] OP_START   = 4'd3;
    localparam logic [3:0] OP_TIMEOUT = 4'd4;
    localparam logic [3:0] OP_ACK     = 4'd5;
    localparam logic [3:0] OP_PHASE   = 4'd6;
    localparam logic [3:0] OP_AVOID   = 4'd7;
    localparam logic [3:0] OP_POP     = 4'd8;
    localparam logic [3:0] OP_POP2    = 4'd9;
    localparam logic [3:0] OP_SEND    = 4'd10;
    localparam logic [3:0] OP_NSEG    = 4'd11;
    localparam logic [3:0] OP_AVAIL   = 4'd12;
    localparam logic [3:0] OP_COMMIT  = 4'd13;
    localparam logic [3:0] OP_FINISH  = 4'd14;

    // divider operand selects
    localparam logic [1:0] DIV_AVOID = 2'd0;
    localparam logic [1:0] DIV_DIFF  = 2'd1;
    localparam logic [1:0] DIV_ROOM  = 2'd2;
    localparam logic [1:0] DIV_REM   = 2'd3;

    typedef struct packed {
        logic [15:0]        seg;
        logic [TOTAL_W-1:0] total;
        logic [10:0]        init_lim;
        logic [10:0]        to_win;
        logic [6:0]         burst;
        logic [3:0]         trig;
    } cfg_t;

    typedef struct packed {
        logic [3:0] op;
        logic       div_start;
        logic [1:0] div_sel;
        logic       idle;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       unack_nz;
        logic       ack_new;
        logic       ack_dup;
        logic       go_avoid;
        logic       pop_all;
        logic       rem_zero;
        logic       cnt_zero;
        logic       div_done;
        logic       out_free;
    } sts_t;

endpackage

// ===== design/tcwc_cfg.sv =====
// Configuration register file behind the APB-style port.
// Depends on tcwc_pkg.
module tcwc_cfg
    import tcwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // write a register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg      <= SEG_RESET;
            cfg_reg.total    <= '0;
            cfg_reg.init_lim <= INIT_LIM_RESET;
            cfg_reg.to_win   <= TO_WIN_RESET;
            cfg_reg.burst    <= BURST_RESET;
            cfg_reg.trig     <= TRIG_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                REG_SEG:      cfg_reg.seg      <= pwdata[15:0];
                REG_TOTAL:    cfg_reg.total    <= pwdata[TOTAL_W-1:0];
                REG_INIT_LIM: cfg_reg.init_lim <= pwdata[10:0];
                REG_TO_WIN:   cfg_reg.to_win   <= pwdata[10:0];
                REG_BURST:    cfg_reg.burst    <= pwdata[6:0];
                REG_TRIG:     cfg_reg.trig     <= pwdata[3:0];
                default:      ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[5:3])
            REG_SEG:      prdata = DATA_W'(cfg_reg.seg);
            REG_TOTAL:    prdata = DATA_W'(cfg_reg.total);
            REG_INIT_LIM: prdata = DATA_W'(cfg_reg.init_lim);
            REG_TO_WIN:   prdata = DATA_W'(cfg_reg.to_win);
            REG_BURST:    prdata = DATA_W'(cfg_reg.burst);
            REG_TRIG:     prdata = DATA_W'(cfg_reg.trig);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== design/tcwc_divider.sv =====
// Restoring divider, one quotient bit per cycle, done pulses after DIV_W steps.
// Depends on tcwc_pkg for the default of DIV_W.
module tcwc_divider
    import tcwc_pkg::*;
#(
    parameter int DIV_W = SEQ_W_DEF,
    parameter int DVS_W = 26
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quo,
    output logic [DVS_W-1:0] rmd,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg;
    logic [DVS_W-1:0] r_reg;
    logic [DVS_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {r_reg, q_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, d_reg};
    assign quo   = q_reg;
    assign rmd   = r_reg;
    assign done  = done_reg;

    // count the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DIV_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift in one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                r_reg <= DVS_W'(trial - {1'b0, d_reg});
                q_reg <= {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[DVS_W-1:0];
                q_reg <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== design/tcwc_datapath.sv =====
// Datapath: window state, sequence state, shared multiplier, divider and the
// result register. Depends on tcwc_pkg and tcwc_divider.
module tcwc_datapath
    import tcwc_pkg::*;
#(
    parameter int MAX_WIN_SEG = MAX_WIN_SEG_DEF,
    parameter int SEQ_W       = SEQ_W_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  cmd_t             cmd,
    input  logic [1:0]       mode,
    input  logic [SEQ_W-1:0] ack_index,
    input  logic             out_stall,
    output sts_t             sts,
    output logic             out_valid,
    output logic [10:0]      new_count,
    output logic [SEQ_W-1:0] new_first_seq,
    output logic [15:0]      new_last_bytes,
    output logic [6:0]       resend_count,
    output logic [SEQ_W-1:0] resend_first_seq,
    output logic [25:0]      current_window,
    output logic [25:0]      current_limit,
    output logic [1:0]       phase_out,
    output logic             transfer_done
);

    localparam int WIN_W = $clog2(MAX_WIN_SEG * 65535 + 1);
    localparam int CNT_W = $clog2(MAX_WIN_SEG + 1);
    localparam int DIV_W = (SEQ_W > TOTAL_W) ? SEQ_W : TOTAL_W;
    localparam logic [WIN_W-1:0] LIM_RESET = WIN_W'(
        ((MAX_WIN_SEG < 512) ? MAX_WIN_SEG : 512) * 4000);

    function automatic logic [WIN_W-1:0] clamp_win(input logic [31:0] v,
                                                   input logic [15:0] s,
                                                   input logic [WIN_W-1:0] mx);
        if (v < 32'(s))
            return WIN_W'(s);
        else if (v > 32'(mx))
            return mx;
        else
            return WIN_W'(v);
    endfunction

    function automatic logic [WIN_W-1:0] clamp_lim(input logic [31:0] v,
                                                   input logic [WIN_W-1:0] mx);
        if (v > 32'(mx))
            return mx;
        else
            return WIN_W'(v);
    endfunction

    // state
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [WIN_W-1:0]   lim_reg, lim_next;
    logic [1:0]         phase_reg, phase_next;
    logic [3:0]         dup_reg, dup_next;
    logic [SEQ_W-1:0]   oldest_reg, oldest_next;
    logic [SEQ_W-1:0]   nxt_reg, nxt_next;
    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic [10:0]        unack_reg, unack_next;
    // per-event working values
    logic [1:0]         mode_reg, mode_next;
    logic [SEQ_W-1:0]   ack_reg, ack_next;
    logic [WIN_W-1:0]   maxw_reg, maxw_next;
    logic [19:0]        trigs_reg, trigs_next;
    logic [31:0]        prod_reg, prod_next;
    logic [10:0]        pop_reg, pop_next;
    logic [CNT_W-1:0]   npk_reg, npk_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               full_reg, full_next;
    logic [CNT_W-1:0]   rn_reg, rn_next;
    logic [SEQ_W-1:0]   nf_reg, nf_next;
    logic [15:0]        nl_reg, nl_next;
    logic [6:0]         rsn_reg, rsn_next;
    logic [SEQ_W-1:0]   rsf_reg, rsf_next;
    logic               out_valid_reg, out_valid_next;

    logic [15:0]        seg;
    logic [3:0]         trig;
    logic [15:0]        mul_a;
    logic [DIV_W-1:0]   dvd;
    logic [WIN_W-1:0]   dvs;
    logic [DIV_W-1:0]   quo;
    logic [WIN_W-1:0]   rmd;
    logic               div_done;
    logic [DIV_W-1:0]   ceilq;
    logic [WIN_W-1:0]   room;
    logic               use_n;
    logic [CNT_W-1:0]   cnt;
    logic [WIN_W-1:0]   half;
    logic [WIN_W-1:0]   half_s;
    logic [WIN_W-1:0]   lim_rec;
    logic [31:0]        tw_half;
    logic [TOTAL_W-1:0] sent;
    logic               out_take;

    assign seg  = (cfg.seg == '0) ? 16'd1 : cfg.seg;
    assign trig = (cfg.trig == '0) ? 4'd1 : cfg.trig;

    // shared divider
    tcwc_divider #(.DIV_W(DIV_W), .DVS_W(WIN_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .quo      (quo),
        .rmd      (rmd),
        .done     (div_done)
    );

    // derived values
    assign room    = (32'(win_reg) > prod_reg) ? WIN_W'(32'(win_reg) - prod_reg) : '0;
    assign ceilq   = quo + DIV_W'(rmd != '0);
    assign use_n   = DIV_W'(npk_reg) < ceilq;
    assign cnt     = use_n ? npk_reg : CNT_W'(ceilq);
    assign half    = win_reg >> 1;
    assign half_s  = (half < WIN_W'(seg)) ? WIN_W'(seg) : half;
    assign lim_rec = clamp_lim(32'(half_s), maxw_reg);
    assign tw_half = (32'(half) > prod_reg) ? 32'(half) : prod_reg;
    assign sent    = full_reg ? rem_reg : TOTAL_W'(prod_reg);
    assign out_take = out_valid_reg & ~out_stall;

    // status to the controller
    always_comb
    begin
        sts.mode     = mode_reg;
        sts.unack_nz = unack_reg != '0;
        sts.ack_new  = ack_reg > oldest_reg;
        sts.ack_dup  = ack_reg == oldest_reg;
        sts.go_avoid = (phase_reg == PH_AVOID) && (dup_reg == '0);
        sts.pop_all  = ceilq >= DIV_W'(unack_reg);
        sts.rem_zero = rem_reg == '0;
        sts.cnt_zero = cnt == '0;
        sts.div_done = div_done;
        sts.out_free = ~out_valid_reg | ~out_stall;
    end

    // select divider operands
    always_comb
    begin
        case (cmd.div_sel)
            DIV_AVOID:
            begin
                dvd = DIV_W'(prod_reg);
                dvs = win_reg;
            end
            DIV_DIFF:
            begin
                dvd = DIV_W'(ack_reg - oldest_reg);
                dvs = WIN_W'(seg);
            end
            DIV_ROOM:
            begin
                dvd = DIV_W'(room);
                dvs = WIN_W'(seg);
            end
            default:
            begin
                dvd = DIV_W'(rem_reg);
                dvs = WIN_W'(seg);
            end
        endcase
    end

    // select multiplier operand; the other operand is always the segment size
    always_comb
    begin
        case (cmd.op)
            OP_LATCH: mul_a = 16'(MAX_WIN_SEG);
            OP_MAXW:
            begin
                case (mode_reg)
                    MODE_START:   mul_a = 16'(cfg.init_lim);
                    MODE_TIMEOUT: mul_a = 16'(cfg.to_win);
                    default:      mul_a = 16'(trig);
                endcase
            end
            OP_ACK:   mul_a = seg;
            OP_POP:   mul_a = 16'(ceilq[10:0]);
            OP_SEND:  mul_a = 16'(unack_reg);
            OP_AVAIL: mul_a = use_n ? 16'(cnt) : 16'(cnt - 1'b1);
            default:  mul_a = '0;
        endcase
    end

    assign prod_next = 32'(mul_a) * 32'(seg);

    // apply the current command
    always_comb
    begin
        win_next       = win_reg;
        lim_next       = lim_reg;
        phase_next     = phase_reg;
        dup_next       = dup_reg;
        oldest_next    = oldest_reg;
        nxt_next       = nxt_reg;
        rem_next       = rem_reg;
        unack_next     = unack_reg;
        mode_next      = mode_reg;
        ack_next       = ack_reg;
        maxw_next      = maxw_reg;
        trigs_next     = trigs_reg;
        pop_next       = pop_reg;
        npk_next       = npk_reg;
        cnt_next       = cnt_reg;
        full_next      = full_reg;
        rn_next        = rn_reg;
        nf_next        = nf_reg;
        nl_next        = nl_reg;
        rsn_next       = rsn_reg;
        rsf_next       = rsf_reg;
        out_valid_next = out_valid_reg & ~out_take;

        case (cmd.op)
            OP_LATCH:
            begin
                mode_next = mode;
                ack_next  = ack_index;
                rn_next   = '0;
                nl_next   = '0;
                rsn_next  = '0;
            end
            OP_MAXW:
            begin
                maxw_next = WIN_W'(prod_reg);
            end
            OP_START:
            begin
                win_next    = WIN_W'(seg);
                lim_next    = clamp_lim(prod_reg, maxw_reg);
                phase_next  = PH_SLOW;
                dup_next    = '0;
                oldest_next = '0;
                nxt_next    = '0;
                rem_next    = cfg.total;
                unack_next  = '0;
            end
            OP_TIMEOUT:
            begin
                if (unack_reg != '0)
                begin
                    lim_next   = clamp_lim(tw_half, maxw_reg);
                    win_next   = clamp_win(prod_reg, seg, maxw_reg);
                    phase_next = PH_SLOW;
                    rsn_next   = (11'(cfg.burst) < unack_reg) ? cfg.burst : 7'(unack_reg);
                    rsf_next   = oldest_reg;
                    dup_next   = '0;
                end
            end
            OP_ACK:
            begin
                trigs_next = prod_reg[19:0];
                if (unack_reg != '0)
                begin
                    if (ack_reg == oldest_reg)
                    begin
                        if (dup_reg != DUP_MAX)
                        begin
                            dup_next = dup_reg + 1'b1;
                        end
                    end
                    else if (ack_reg > oldest_reg)
                    begin
                        dup_next = '0;
                    end
                end
            end
            OP_PHASE:
            begin
                case (phase_reg)
                    PH_SLOW, PH_AVOID:
                    begin
                        if (dup_reg >= trig)
                        begin
                            lim_next   = lim_rec;
                            win_next   = clamp_win(32'(lim_rec) + 32'(trigs_reg), seg,
                                                   maxw_reg);
                            phase_next = PH_RECOV;
                            rsn_next   = 7'd1;
                            rsf_next   = oldest_reg;
                            dup_next   = '0;
                        end
                        else if (dup_reg == '0 && phase_reg == PH_SLOW)
                        begin
                            if (win_reg >= lim_reg)
                                phase_next = PH_AVOID;
                            else
                                win_next = clamp_win(32'(win_reg) + 32'(seg), seg, maxw_reg);
                        end
                    end
                    PH_RECOV:
                    begin
                        if (dup_reg != '0)
                        begin
                            win_next = clamp_win(32'(win_reg) + 32'(seg), seg, maxw_reg);
                        end
                        else
                        begin
                            win_next   = clamp_win(32'(lim_reg), seg, maxw_reg);
                            phase_next = PH_AVOID;
                        end
                    end
                    default: ;
                endcase
            end
            OP_AVOID:
            begin
                win_next = clamp_win(32'(win_reg) + 32'(quo[16:0]), seg, maxw_reg);
            end
            OP_POP:
            begin
                if (ceilq >= DIV_W'(unack_reg))
                begin
                    unack_next  = '0;
                    oldest_next = nxt_reg;
                end
                else
                begin
                    pop_next = ceilq[10:0];
                end
            end
            OP_POP2:
            begin
                unack_next  = unack_reg - pop_reg;
                oldest_next = oldest_reg + SEQ_W'(prod_reg);
            end
            OP_NSEG:
            begin
                npk_next = CNT_W'(ceilq);
            end
            OP_AVAIL:
            begin
                cnt_next  = cnt;
                full_next = ~use_n;
            end
            OP_COMMIT:
            begin
                rn_next    = cnt_reg;
                nf_next    = nxt_reg;
                nl_next    = full_reg ? 16'(rem_reg - TOTAL_W'(prod_reg)) : seg;
                nxt_next   = nxt_reg + SEQ_W'(sent);
                rem_next   = rem_reg - sent;
                unack_next = unack_reg + 11'(cnt_reg);
            end
            OP_FINISH:
            begin
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= WIN_W'(SEG_RESET);
            lim_reg       <= LIM_RESET;
            phase_reg     <= PH_SLOW;
            dup_reg       <= '0;
            oldest_reg    <= '0;
            nxt_reg       <= '0;
            rem_reg       <= '0;
            unack_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            lim_reg       <= lim_next;
            phase_reg     <= phase_next;
            dup_reg       <= dup_next;
            oldest_reg    <= oldest_next;
            nxt_reg       <= nxt_next;
            rem_reg       <= rem_next;
            unack_reg     <= unack_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        ack_reg   <= ack_next;
        maxw_reg  <= maxw_next;
        trigs_reg <= trigs_next;
        prod_reg  <= prod_next;
        pop_reg   <= pop_next;
        npk_reg   <= npk_next;
        cnt_reg   <= cnt_next;
        full_reg  <= full_next;
        rn_reg    <= rn_next;
        nf_reg    <= nf_next;
        nl_reg    <= nl_next;
        rsn_reg   <= rsn_next;
        rsf_reg   <= rsf_next;
    end

    // load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            new_count        <= 11'(rn_reg);
            new_first_seq    <= (rn_reg == '0) ? nxt_reg : nf_reg;
            new_last_bytes   <= nl_reg;
            resend_count     <= rsn_reg;
            resend_first_seq <= (rsn_reg == '0) ? oldest_reg : rsf_reg;
            current_window   <= 26'(win_reg);
            current_limit    <= 26'(lim_reg);
            phase_out        <= phase_reg;
            transfer_done    <= (rem_reg == '0) && (unack_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/tcwc_ctrl.sv =====
// Controller: sequences the datapath through the steps of one event.
// Depends on tcwc_pkg.
module tcwc_ctrl
    import tcwc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MAXW    = 5'd1;
    localparam logic [4:0] S_START   = 5'd2;
    localparam logic [4:0] S_TIMEOUT = 5'd3;
    localparam logic [4:0] S_ACK     = 5'd4;
    localparam logic [4:0] S_PHASE   = 5'd5;
    localparam logic [4:0] S_AVOID_W = 5'd6;
    localparam logic [4:0] S_POP_D   = 5'd7;
    localparam logic [4:0] S_POP_W   = 5'd8;
    localparam logic [4:0] S_POP2    = 5'd9;
    localparam logic [4:0] S_SEND    = 5'd10;
    localparam logic [4:0] S_ROOM_D  = 5'd11;
    localparam logic [4:0] S_ROOM_W  = 5'd12;
    localparam logic [4:0] S_REM_D   = 5'd13;
    localparam logic [4:0] S_REM_W   = 5'd14;
    localparam logic [4:0] S_COMMIT  = 5'd15;
    localparam logic [4:0] S_FINISH  = 5'd16;

    logic [4:0] state_reg, state_next;

    // next state and command
    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_AVOID;
        cmd.idle      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_MAXW;
                end
            end
            S_MAXW:
            begin
                cmd.op = OP_MAXW;
                case (sts.mode)
                    MODE_START:   state_next = S_START;
                    MODE_ACK:     state_next = S_ACK;
                    MODE_TIMEOUT: state_next = S_TIMEOUT;
                    default:      state_next = S_FINISH;
                endcase
            end
            S_START:
            begin
                cmd.op     = OP_START;
                state_next = S_SEND;
            end
            S_TIMEOUT:
            begin
                cmd.op     = OP_TIMEOUT;
                state_next = S_FINISH;
            end
            S_ACK:
            begin
                cmd.op = OP_ACK;
                if (sts.unack_nz && (sts.ack_dup || sts.ack_new))
                    state_next = S_PHASE;
                else
                    state_next = S_FINISH;
            end
            S_PHASE:
            begin
                cmd.op = OP_PHASE;
                if (sts.go_avoid)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_AVOID;
                    state_next    = S_AVOID_W;
                end
                else if (sts.ack_new)
                    state_next = S_POP_D;
                else
                    state_next = S_FINISH;
            end
            S_AVOID_W:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = OP_AVOID;
                    state_next = S_POP_D;
                end
            end
            S_POP_D:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DIFF;
                state_next    = S_POP_W;
            end
            S_POP_W:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = OP_POP;
                    state_next = sts.pop_all ? S_SEND : S_POP2;
                end
            end
            S_POP2:
            begin
                cmd.op     = OP_POP2;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                cmd.op     = OP_SEND;
                state_next = sts.rem_zero ? S_FINISH : S_ROOM_D;
            end
            S_ROOM_D:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ROOM;
                state_next    = S_ROOM_W;
            end
            S_ROOM_W:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = OP_NSEG;
                    state_next = S_REM_D;
                end
            end
            S_REM_D:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_REM;
                state_next    = S_REM_W;
            end
            S_REM_W:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = OP_AVAIL;
                    state_next = sts.cnt_zero ? S_FINISH : S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/tcp_congestion_window_controller.sv =====
// Top level of the congestion window controller: configuration port,
// controller and datapath. Depends on tcwc_pkg, tcwc_cfg, tcwc_ctrl, tcwc_datapath.
//
// Usage: an event request (mode, ack_index) enters on in_valid/in_stall and is
// accepted when in_valid is high and in_stall low. Each event gives exactly one
// result request on out_valid/out_stall, held steady while out_stall is high.
// One event is processed at a time; in_stall is high from acceptance until
// the result is written to the output register, and the next event is taken
// while that result still waits for the receiver.
// Each event needs a number of divisions on the shared bit-serial divider,
// each of D = max(SEQ_WIDTH, 48) divider steps of one bit per cycle:
//   unused mode, timeout or ignored acknowledgement: no division
//   start: two divisions, none with no data
//   acknowledgement: up to four divisions; a duplicate that changes no
//   segments needs none.
// The next request can be accepted in the cycle after the result is loaded.
// When the receiver stalls, the finished event waits in its last step until the
// output register frees.
// Reset: window one segment, limit initial segments times segment size,
// slow start, no outstanding data, registers at their reset values.
// Registers are written over the APB-style port at byte address 8*index.
module tcp_congestion_window_controller
    import tcwc_pkg::*;
#(
    parameter int MAX_WINDOW_SEGMENTS = MAX_WIN_SEG_DEF,
    parameter int SEQ_WIDTH           = SEQ_W_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [SEQ_WIDTH-1:0] ack_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [10:0]          new_count,
    output logic [SEQ_WIDTH-1:0] new_first_seq,
    output logic [15:0]          new_last_bytes,
    output logic [6:0]           resend_count,
    output logic [SEQ_WIDTH-1:0] resend_first_seq,
    output logic [25:0]          current_window,
    output logic [25:0]          current_limit,
    output logic [1:0]           phase_out,
    output logic                 transfer_done
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    assign in_stall = ~cmd.idle;

    tcwc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcwc_datapath #(
        .MAX_WIN_SEG (MAX_WINDOW_SEGMENTS),
        .SEQ_W       (SEQ_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .mode             (mode),
        .ack_index        (ack_index),
        .out_stall        (out_stall),
        .sts              (sts),
        .out_valid        (out_valid),
        .new_count        (new_count),
        .new_first_seq    (new_first_seq),
        .new_last_bytes   (new_last_bytes),
        .resend_count     (resend_count),
        .resend_first_seq (resend_first_seq),
        .current_window   (current_window),
        .current_limit    (current_limit),
        .phase_out        (phase_out),
        .transfer_done    (transfer_done)
    );

    // an accepted event keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting an event");

    // a fresh result only appears while the controller is finishing an event
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.op == OP_FINISH))
        else $error("result appeared without a finishing step");

    // reported phase is always a defined phase
    a_phase_defined: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase_out == PH_SLOW || phase_out == PH_AVOID ||
                       phase_out == PH_RECOV))
        else $error("undefined phase reported");

    // hold a stalled result steady
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({new_count, new_first_seq, new_last_bytes, resend_count,
                     resend_first_seq, current_window, current_limit, phase_out,
                     transfer_done}))
        else $error("stalled result changed");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for tcp_congestion_window_controller: a clocked driver and
// monitor around the block, with a transaction-level window predictor in SystemVerilog.
// Depends on tcwc_pkg and the controller RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcwc_pkg::*;

    localparam longint unsigned SEQM = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint unsigned MAXSEG = 1024;
    localparam int CYCLE_LIMIT = 3000000;

    // ack_index choices, resolved when a request is loaded
    typedef enum int { K_SPAN, K_DUP, K_OLD, K_RAND, K_MAX, K_ZERO } ack_kind_t;

    typedef struct {
        logic [1:0]  md;
        ack_kind_t   kind;
        int unsigned rnd;
    } event_req_t;

    typedef struct {
        logic [10:0] ncnt;
        logic [47:0] nfirst;
        logic [15:0] nlast;
        logic [6:0]  rcnt;
        logic [47:0] rfirst;
        logic [25:0] win;
        logic [25:0] lim;
        logic [1:0]  ph;
        logic        done;
    } window_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] mode = MODE_START;
    logic [47:0] ack_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [10:0] new_count;
    logic [47:0] new_first_seq;
    logic [15:0] new_last_bytes;
    logic [6:0] resend_count;
    logic [47:0] resend_first_seq;
    logic [25:0] current_window, current_limit;
    logic [1:0] phase_out;
    logic transfer_done;

    tcp_congestion_window_controller u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .ack_index(ack_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_count(new_count), .new_first_seq(new_first_seq),
        .new_last_bytes(new_last_bytes), .resend_count(resend_count),
        .resend_first_seq(resend_first_seq), .current_window(current_window),
        .current_limit(current_limit), .phase_out(phase_out),
        .transfer_done(transfer_done)
    );

    always #10 clk = ~clk;

    event_req_t pending_events[$];
    window_result_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int hold_cnt = 0;

    // predictor copy of registers and state
    longint unsigned c_seg, c_total, c_init, c_tow, c_burst, c_trig;
    longint unsigned w_bytes, ss_lim, cur_ph, dups, oldest, nxt, remain, unacked;
    longint unsigned r_nn, r_nf, r_nl, r_rn, r_rf;

    function automatic longint unsigned segsz();
        return (c_seg != 0) ? c_seg : 1;
    endfunction

    function automatic longint unsigned trg();
        return (c_trig != 0) ? c_trig : 1;
    endfunction

    function automatic longint unsigned clampw(longint unsigned v);
        if (v < segsz()) v = segsz();
        if (v > MAXSEG * segsz()) v = MAXSEG * segsz();
        return v;
    endfunction

    function automatic longint unsigned clampl(longint unsigned v);
        return (v > MAXSEG * segsz()) ? MAXSEG * segsz() : v;
    endfunction

    task automatic predictor_reset();
        c_seg = SEG_RESET; c_total = 0; c_init = INIT_LIM_RESET;
        c_tow = TO_WIN_RESET; c_burst = BURST_RESET; c_trig = TRIG_RESET;
        w_bytes = segsz(); ss_lim = clampl(c_init * segsz());
        cur_ph = PH_SLOW; dups = 0; oldest = 0; nxt = 0; remain = 0; unacked = 0;
    endtask

    task automatic enter_recovery();
        longint unsigned h;
        h = w_bytes / 2;
        if (h < segsz()) h = segsz();
        ss_lim = clampl(h);
        w_bytes = clampw(ss_lim + trg() * segsz());
        cur_ph = PH_RECOV;
        if (unacked != 0)
        begin
            r_rn = 1;
            r_rf = oldest;
        end
        dups = 0;
    endtask

    task automatic grow_window();
        longint unsigned s;
        s = segsz();
        if (cur_ph == PH_SLOW || cur_ph == PH_AVOID)
        begin
            if (dups >= trg())
                enter_recovery();
            else if (dups == 0)
            begin
                if (cur_ph == PH_SLOW)
                begin
                    if (w_bytes >= ss_lim)
                        cur_ph = PH_AVOID;
                    else
                        w_bytes = clampw(w_bytes + s);
                end
                else
                    w_bytes = clampw(w_bytes + (s * s) / w_bytes);
            end
        end
        else if (cur_ph == PH_RECOV)
        begin
            if (dups > 0)
                w_bytes = clampw(w_bytes + s);
            else
            begin
                w_bytes = clampw(ss_lim);
                cur_ph = PH_AVOID;
            end
        end
    endtask

    task automatic send_segments();
        longint unsigned s, inflight, room, n, avail, cnt, sent, last;
        s = segsz();
        if (remain == 0) return;
        inflight = unacked * s;
        room = (w_bytes > inflight) ? w_bytes - inflight : 0;
        n = room / s + ((room % s) != 0);
        avail = remain / s + ((remain % s) != 0);
        cnt = (n < avail) ? n : avail;
        if (cnt == 0) return;
        if (cnt == avail)
        begin
            sent = remain;
            last = remain - (cnt - 1) * s;
        end
        else
        begin
            sent = cnt * s;
            last = s;
        end
        r_nn = cnt; r_nf = nxt; r_nl = last;
        nxt = (nxt + sent) & SEQM;
        remain -= sent;
        unacked = (unacked + cnt) & 64'h7FF;
    endtask

    task automatic predict_window(input logic [1:0] md, input logic [47:0] ack_in,
                                  output window_result_t r);
        longint unsigned s, ack, diff, pop, tw, h;
        s = segsz();
        ack = ack_in;
        r_nn = 0; r_nl = 0; r_rn = 0;
        if (md == MODE_START)
        begin
            w_bytes = s; ss_lim = clampl(c_init * s); cur_ph = PH_SLOW; dups = 0;
            oldest = 0; nxt = 0; remain = c_total; unacked = 0; r_rf = 0;
            send_segments();
        end
        else if (md == MODE_ACK)
        begin
            r_rf = oldest;
            if (unacked != 0)
            begin
                if (ack == oldest)
                begin
                    if (dups < DUP_MAX) dups++;
                    grow_window();
                end
                else if (ack > oldest)
                begin
                    diff = ack - oldest;
                    pop = diff / s + ((diff % s) != 0);
                    dups = 0;
                    grow_window();
                    if (pop >= unacked)
                    begin
                        unacked = 0;
                        oldest = nxt;
                    end
                    else
                    begin
                        unacked -= pop;
                        oldest = (oldest + pop * s) & SEQM;
                    end
                    send_segments();
                end
            end
        end
        else if (md == MODE_TIMEOUT)
        begin
            r_rf = oldest;
            if (unacked != 0)
            begin
                tw = c_tow * s;
                h = w_bytes / 2;
                ss_lim = clampl((h > tw) ? h : tw);
                w_bytes = clampw(tw);
                cur_ph = PH_SLOW;
                r_rn = (c_burst < unacked) ? c_burst : unacked;
                dups = 0;
            end
        end
        else
            r_rf = oldest;
        if (r_nn == 0) r_nf = nxt;
        if (r_rn == 0) r_rf = oldest;
        r.ncnt = r_nn[10:0]; r.nfirst = r_nf[47:0]; r.nlast = r_nl[15:0];
        r.rcnt = r_rn[6:0]; r.rfirst = r_rf[47:0];
        r.win = w_bytes[25:0]; r.lim = ss_lim[25:0]; r.ph = cur_ph[1:0];
        r.done = (remain == 0 && unacked == 0);
    endtask

    // choose an acknowledgement number from the current predicted state
    function automatic logic [47:0] pick_ack(ack_kind_t k, int unsigned rnd);
        longint unsigned span, a;
        span = (nxt - oldest) & SEQM;
        case (k)
            K_SPAN:
            begin
                a = rnd % (span + 2 * segsz() + 1);
                if (rnd[31]) a = (a / segsz()) * segsz();
                a = (oldest + a) & SEQM;
            end
            K_DUP:  a = oldest;
            K_OLD:  a = (oldest - 1 - (rnd % 2000)) & SEQM;
            K_MAX:  a = SEQM;
            K_ZERO: a = 0;
            default: a = {$urandom, $urandom} & SEQM;
        endcase
        return a[47:0];
    endfunction

    // driver: predict on acceptance, then load the next request
    always @(posedge clk)
    begin : drive_events
        event_req_t it;
        window_result_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_window(mode, ack_index, r);
                expected_results.push_back(r);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_events.size() > 0 && !(idle_on && $urandom_range(99) < 21))
                begin
                    it = pending_events.pop_front();
                    in_valid <= 1'b1;
                    mode <= it.md;
                    if (it.md == MODE_ACK)
                        ack_index <= pick_ack(it.kind, it.rnd);
                    else
                        ack_index <= 48'({$urandom, $urandom});
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(string fname, longint unsigned got, longint unsigned exp_v);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", fname, got, exp_v, cycles);
        errors++;
    endtask

    // monitor: compare results and drive the receiver stall
    always @(posedge clk)
    begin : watch_results
        window_result_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    e = expected_results.pop_front();
                    if (new_count !== e.ncnt) report_mismatch("new_count", new_count, e.ncnt);
                    if (new_first_seq !== e.nfirst)
                        report_mismatch("new_first_seq", new_first_seq, e.nfirst);
                    if (new_last_bytes !== e.nlast)
                        report_mismatch("new_last_bytes", new_last_bytes, e.nlast);
                    if (resend_count !== e.rcnt)
                        report_mismatch("resend_count", resend_count, e.rcnt);
                    if (resend_first_seq !== e.rfirst)
                        report_mismatch("resend_first_seq", resend_first_seq, e.rfirst);
                    if (current_window !== e.win)
                        report_mismatch("current_window", current_window, e.win);
                    if (current_limit !== e.lim)
                        report_mismatch("current_limit", current_limit, e.lim);
                    if (phase_out !== e.ph) report_mismatch("phase_out", phase_out, e.ph);
                    if (transfer_done !== e.done)
                        report_mismatch("transfer_done", transfer_done, e.done);
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = 1500;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idle_on && ($urandom_range(99) < 21);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, longint unsigned v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx); pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SEG:      c_seg = v & 64'hFFFF;
            REG_TOTAL:    c_total = v & SEQM;
            REG_INIT_LIM: c_init = v & 64'h7FF;
            REG_TO_WIN:   c_tow = v & 64'h7FF;
            REG_BURST:    c_burst = v & 64'h7F;
            REG_TRIG:     c_trig = v & 64'hF;
            default: ;
        endcase
    endtask

    task automatic configure(longint unsigned seg, longint unsigned total,
                             longint unsigned init, longint unsigned tow,
                             longint unsigned burst, longint unsigned trig);
        reg_write(REG_SEG, seg);
        reg_write(REG_TOTAL, total);
        reg_write(REG_INIT_LIM, init);
        reg_write(REG_TO_WIN, tow);
        reg_write(REG_BURST, burst);
        reg_write(REG_TRIG, trig);
    endtask

    task automatic push_event(logic [1:0] md, ack_kind_t k);
        event_req_t it;
        it.md = md; it.kind = k; it.rnd = $urandom;
        pending_events.push_back(it);
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // mostly well-formed transfer traffic with some noise
    task automatic push_random(int n);
        int cnt, p, j, burst_len;
        cnt = 0;
        push_event(MODE_START, K_SPAN);
        while (cnt < n)
        begin
            p = $urandom_range(99);
            if (p < 58)
            begin
                push_event(MODE_ACK, K_SPAN); cnt++;
            end
            else if (p < 72)
            begin
                burst_len = $urandom_range(1, 18);
                for (j = 0; j < burst_len; j++)
                    push_event(MODE_ACK, K_DUP);
                cnt += burst_len;
            end
            else if (p < 80)
            begin
                push_event(MODE_TIMEOUT, K_SPAN); cnt++;
            end
            else if (p < 83)
            begin
                push_event(MODE_START, K_SPAN); cnt++;
            end
            else if (p < 90)
            begin
                push_event(MODE_ACK, K_RAND); cnt++;
            end
            else if (p < 95)
            begin
                push_event(MODE_ACK, K_OLD); cnt++;
            end
            else
            begin
                push_event(MODE_UNUSED, K_SPAN); cnt++;
            end
        end
    endtask

    initial
    begin : stimulus
        int ph;
        longint unsigned seg, total;
        predictor_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty transfer, recovery entry, timeout, odd modes and acks
        push_event(MODE_START, K_SPAN);
        push_event(MODE_ACK, K_DUP);
        push_event(MODE_TIMEOUT, K_SPAN);
        push_event(MODE_UNUSED, K_SPAN);
        drain();
        configure(1000, 20500, 4, 2, 3, 3);
        push_event(MODE_START, K_SPAN);
        repeat (4) push_event(MODE_ACK, K_DUP);
        push_event(MODE_ACK, K_SPAN);
        push_event(MODE_ACK, K_OLD);
        push_event(MODE_ACK, K_ZERO);
        push_event(MODE_TIMEOUT, K_SPAN);
        push_event(MODE_UNUSED, K_SPAN);
        push_event(MODE_ACK, K_SPAN);
        push_event(MODE_ACK, K_SPAN);
        push_event(MODE_ACK, K_MAX);
        push_event(MODE_TIMEOUT, K_SPAN);
        push_event(MODE_ACK, K_DUP);
        push_event(MODE_START, K_SPAN);
        push_event(MODE_ACK, K_RAND);
        drain();

        for (ph = 0; ph < 11; ph++)
        begin
            seg = $urandom_range(1, 65535);
            if ($urandom_range(1)) seg = $urandom_range(1, 200);
            total = seg * $urandom_range(1, 3000) + $urandom_range(0, 999);
            case (ph)
                0: configure(1, 5000, 1, 1, 1, 1);
                1: configure(65535, SEQM, 1024, 1024, 64, 15);
                2: configure(0, 3000, 2047, 2047, 127, 0);
                3: configure(seg, total, 1024, 1, 64, 1);
                default: configure(seg, total, $urandom_range(0, 2047),
                                   $urandom_range(0, 2047), $urandom_range(0, 127),
                                   $urandom_range(0, 15));
            endcase
            idle_on = (ph != 5);
            if (ph == 4) hold_req = 1'b1;
            push_random(115);
            drain();
        end
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
